// File: hw/rtl/nfpa_pkg.sv
// ----------------------------------------------------------------------------
// nfpa_pkg
// Shared types and constants for the next-fit port allocator: opcodes,
// status codes, controller states and the bitmap write request.
// ----------------------------------------------------------------------------
package nfpa_pkg;

  localparam int PORT_W  = 16;
  localparam int OFF_W   = 5;                 // bit offset inside a bitmap word
  localparam int WORD_W  = 1 << OFF_W;        // ports per bitmap word
  localparam int ADDR_W  = PORT_W - OFF_W;    // bitmap word address
  localparam int DEPTH   = 1 << ADDR_W;       // bitmap words
  localparam int FREE_W  = 18;                // signed free count
  localparam int VIS_W   = ADDR_W + 1;        // scan word counter

  typedef enum logic {
    OP_BIND    = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_IN_USE      = 2'd1,
    STATUS_NO_FREE     = 2'd2,
    STATUS_REL_IGNORED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } wr_req_t;

endpackage

// File: hw/rtl/nfpa_bitmap.sv
// ----------------------------------------------------------------------------
// nfpa_bitmap
// Port-in-use bitmap: one synchronous memory of 32-bit words, one write and
// one registered read per cycle, with a clearing pass after reset.
// ----------------------------------------------------------------------------
module nfpa_bitmap
  import nfpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  wr_req_t           wr,
  output logic              clear_done
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              clearing_r;

  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [WORD_W-1:0] wd;

  always_comb begin
    we = clearing_r | wr.en;
    wa = clearing_r ? clr_addr_r : wr.addr;
    wd = clearing_r ? '0 : wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data    = rd_data_r;
  assign clear_done = ~clearing_r;

endmodule

// File: hw/rtl/next_fit_port_allocator.sv
// ----------------------------------------------------------------------------
// next_fit_port_allocator
// Binds and releases 16-bit local ports against a used-port bitmap, with
// next-fit ephemeral selection over PORT_FIRST..PORT_LAST.
// ----------------------------------------------------------------------------
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------
//   request  | start, busy        | in_opcode, in_port_number
//   result   | out_valid (strobe) | out_status, out_granted_port
//
// After reset the bitmap is cleared one word a cycle: busy stays high until
// the clearing pass is done once rst_n is released. A release or a bind of a
// named port passes through ST_LOOK once before the next accept; the result
// strobe comes in the cycle busy falls. An ephemeral bind stays in ST_LOOK,
// reading 32-bit bitmap words (one read per cycle on the bitmap port) until
// a free port turns up, the free count runs out or a full pass finds none.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module next_fit_port_allocator
  import nfpa_pkg::*;
#(
  parameter int PORT_FIRST = 32768,
  parameter int PORT_LAST  = 33791
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_opcode,
  input  logic [PORT_W-1:0] in_port_number,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [PORT_W-1:0] out_granted_port
);

  localparam logic [PORT_W-1:0] FIRST_P   = PORT_W'(PORT_FIRST);
  localparam logic [PORT_W-1:0] LAST_P    = PORT_W'(PORT_LAST);
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(PORT_LAST / WORD_W);
  localparam logic [WORD_W-1:0] LAST_MASK =
    {WORD_W{1'b1}} >> (WORD_W - 1 - (PORT_LAST % WORD_W));
  localparam logic signed [FREE_W-1:0] FREE_INIT =
    FREE_W'(PORT_LAST - PORT_FIRST + 1);
  localparam int SCAN_WORDS = (PORT_LAST >= PORT_FIRST) ?
    (PORT_LAST / WORD_W - PORT_FIRST / WORD_W + 2) : 1;

  state_t                    state_r, state_nxt;
  logic [PORT_W-1:0]         cur_r, cur_nxt;
  logic                      op_r, op_nxt;
  logic                      eph_r, eph_nxt;
  logic [VIS_W-1:0]          visits_r, visits_nxt;
  logic [PORT_W-1:0]         next_port_r, next_port_nxt;
  logic signed [FREE_W-1:0]  free_count_r, free_count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                status_r, status_nxt;
  logic [PORT_W-1:0]         granted_r, granted_nxt;

  wr_req_t           wr;
  logic [WORD_W-1:0] rd_data;
  logic              clear_done;

  logic [WORD_W-1:0] bit_sel;
  logic              cur_used;
  logic [WORD_W-1:0] cand;
  logic              found;
  logic [OFF_W-1:0]  found_off;
  logic [PORT_W-1:0] found_port;
  logic              no_free;

  nfpa_bitmap u_bitmap (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_addr    (cur_nxt[PORT_W-1:OFF_W]),
    .rd_data    (rd_data),
    .wr         (wr),
    .clear_done (clear_done)
  );

  // first free port at or above the current one, within the current word and the range
  always_comb begin
    bit_sel  = WORD_W'(1) << cur_r[OFF_W-1:0];
    cur_used = |(rd_data & bit_sel);
    cand     = ~rd_data & ({WORD_W{1'b1}} << cur_r[OFF_W-1:0]);
    if (cur_r[PORT_W-1:OFF_W] == LAST_WORD) begin
      cand = cand & LAST_MASK;
    end
    found     = |cand;
    found_off = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found_off = OFF_W'(i);
      end
    end
    found_port = {cur_r[PORT_W-1:OFF_W], found_off};
    no_free    = free_count_r[FREE_W-1] || (free_count_r == '0);
  end

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    op_nxt         = op_r;
    eph_nxt        = eph_r;
    visits_nxt     = visits_r;
    next_port_nxt  = next_port_r;
    free_count_nxt = free_count_r;
    out_valid_nxt  = 1'b0;
    status_nxt     = status_r;
    granted_nxt    = granted_r;
    wr             = '0;
    wr.addr        = cur_r[PORT_W-1:OFF_W];

    unique case (state_r)
      ST_CLEAR: begin
        if (clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          op_nxt     = in_opcode;
          eph_nxt    = (in_opcode == OP_BIND) && (in_port_number == '0);
          cur_nxt    = eph_nxt ? next_port_r : in_port_number;
          visits_nxt = VIS_W'(1);
          state_nxt  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        granted_nxt = '0;
        if (op_r == OP_RELEASE) begin
          if (cur_used) begin
            wr.en          = 1'b1;
            wr.data        = rd_data & ~bit_sel;
            free_count_nxt = free_count_r + 1'b1;
            status_nxt     = STATUS_OK;
          end else begin
            status_nxt = STATUS_REL_IGNORED;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (!eph_r) begin
          if (cur_used) begin
            status_nxt = STATUS_IN_USE;
          end else begin
            wr.en          = 1'b1;
            wr.data        = rd_data | bit_sel;
            free_count_nxt = free_count_r - 1'b1;
            status_nxt     = STATUS_OK;
            granted_nxt    = cur_r;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (no_free) begin
          status_nxt    = STATUS_NO_FREE;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (found) begin
          wr.en          = 1'b1;
          wr.data        = rd_data | (WORD_W'(1) << found_off);
          free_count_nxt = free_count_r - 1'b1;
          status_nxt     = STATUS_OK;
          granted_nxt    = found_port;
          next_port_nxt  = (found_port == LAST_P) ? FIRST_P : found_port + 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (visits_r >= VIS_W'(SCAN_WORDS)) begin
          // one full pass came up empty
          status_nxt    = STATUS_NO_FREE;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          // advance to the next word, wrap to the start of the range
          if (cur_r[PORT_W-1:OFF_W] == LAST_WORD) begin
            cur_nxt = FIRST_P;
          end else begin
            cur_nxt = {ADDR_W'(cur_r[PORT_W-1:OFF_W] + 1'b1), {OFF_W{1'b0}}};
          end
          visits_nxt = visits_r + 1'b1;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      next_port_r  <= FIRST_P;
      free_count_r <= FREE_INIT;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_port_r  <= next_port_nxt;
      free_count_r <= free_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    op_r      <= op_nxt;
    eph_r     <= eph_nxt;
    visits_r  <= visits_nxt;
    status_r  <= status_nxt;
    granted_r <= granted_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_granted_port = granted_r;

  a_result_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_LOOK))
    else $error("result strobe without a lookup");

  a_failed_grants_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_OK) |-> (out_granted_port == '0))
    else $error("failed transaction granted a port");

  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= FREE_INIT)
    else $error("free count above range size");

  a_eph_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(eph_r) && (out_status == STATUS_OK) |->
      (out_granted_port >= FIRST_P) && (out_granted_port <= LAST_P))
    else $error("ephemeral port outside range");

  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == ST_LOOK) && out_valid_nxt)
    else $error("bitmap write outside a finishing lookup");

endmodule
